// File: hw/rtl/mfmtip_pkg.sv
// Package: constants, phase codes and lead-in helper for the MFM track image parser.
`timescale 1ns / 1ps

package mfmtip_pkg;

    localparam int OUT_BYTES = 5120;
    localparam int OFF_W     = 13;
    localparam int CNT_W     = $clog2(OUT_BYTES + 1);
    localparam int REM_W     = 11;
    localparam int PH_W      = 4;

    localparam logic [7:0] BYTE_GAP     = 8'h4e;
    localparam logic [7:0] BYTE_SYNC    = 8'h00;
    localparam logic [7:0] BYTE_A1      = 8'ha1;
    localparam logic [7:0] BYTE_ID_AM   = 8'hfe;
    localparam logic [7:0] BYTE_DATA_AM = 8'hfb;

    localparam logic [7:0] SIZE_256  = 8'd1;
    localparam logic [7:0] SIZE_512  = 8'd2;
    localparam logic [7:0] SIZE_1024 = 8'd3;

    localparam logic [REM_W-1:0] LEN_256  = REM_W'(256);
    localparam logic [REM_W-1:0] LEN_512  = REM_W'(512);
    localparam logic [REM_W-1:0] LEN_1024 = REM_W'(1024);

    localparam logic [PH_W-1:0] PH_GAP_ID    = 4'd0;
    localparam logic [PH_W-1:0] PH_SYNC_ID   = 4'd1;
    localparam logic [PH_W-1:0] PH_MARK_ID   = 4'd2;
    localparam logic [PH_W-1:0] PH_HEADER    = 4'd3;
    localparam logic [PH_W-1:0] PH_HCRC      = 4'd4;
    localparam logic [PH_W-1:0] PH_GAP_DATA  = 4'd5;
    localparam logic [PH_W-1:0] PH_SYNC_DATA = 4'd6;
    localparam logic [PH_W-1:0] PH_MARK_DATA = 4'd7;
    localparam logic [PH_W-1:0] PH_PAYLOAD   = 4'd8;
    localparam logic [PH_W-1:0] PH_DCRC      = 4'd9;

    typedef struct packed {
        logic            hit;
        logic            err;
        logic [PH_W-1:0] phase;
        logic [1:0]      sync;
    } t_lead;

    // Gap / sync / A1 run ahead of an address mark; base is the gap phase of the field.
    function automatic t_lead f_lead(input logic [PH_W-1:0] phase,
                                     input logic [PH_W-1:0] base,
                                     input logic [1:0]      sync,
                                     input logic [7:0]      b,
                                     input logic [7:0]      mark);
        t_lead           res;
        logic [PH_W-1:0] rel;
        res.hit   = 1'b0;
        res.err   = 1'b0;
        res.phase = phase;
        res.sync  = sync;
        rel       = phase - base;
        if (b == mark) begin
            res.hit = 1'b1;
        end else if (b == BYTE_A1) begin
            if (rel < PH_W'(2)) begin
                res.sync  = 2'd1;
                res.phase = base + PH_W'(2);
            end else if (sync != 2'd3) begin
                res.sync = sync + 2'd1;
            end else begin
                res.err = 1'b1;
            end
        end else if (b == BYTE_SYNC) begin
            if (rel <= PH_W'(1)) begin
                res.phase = base + PH_W'(1);
            end else begin
                res.err = 1'b1;
            end
        end else if (b == BYTE_GAP) begin
            if (rel != '0) begin
                res.err = 1'b1;
            end
        end else begin
            res.err = 1'b1;
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/mfm_track_image_parser_unit.sv
// MFM track image parser: extracts sector payload bytes from a raw track byte stream.
`timescale 1ns / 1ps

// Takes one raw track byte per transfer and walks the IBM System/34 sector grammar
// (gap, sync, A1 run, ID mark, four header bytes, header CRC, gap, sync, A1 run,
// data mark, payload, data CRC). Each payload byte leaves as one transfer with its
// running offset in the decoded track; the byte flagged tlast always gives a
// transfer with tlast set and the track status in tuser. Bytes that are neither
// payload nor track end give no transfer. CRCs are skipped, not checked. After a
// format error the rest of the track is ignored and the end status reads 1.
// Throughput is one byte per clock while i_m_tready does not stall the output: an input
// register, combinational phase logic and an output register lie between input and output.
module mfm_track_image_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] raw_byte
    input  logic        i_s_tlast,   // end_of_track
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] data_byte, [20:8] byte_offset, [23:21] zero
    output logic [1:0]  o_m_tuser,   // [0] data_valid, [1] parse_status
    output logic        o_m_tlast    // track_done
);
    import mfmtip_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;

    logic [PH_W-1:0]  r_phase, n_phase;
    logic [1:0]       r_sync, n_sync;
    logic [2:0]       r_fcnt, n_fcnt;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_off, n_off;
    logic             r_err, n_err;

    logic             r_o_valid;
    logic [7:0]       r_o_byte;
    logic [OFF_W-1:0] r_o_off;
    logic             r_o_dv;
    logic             r_o_last;
    logic             r_o_status;

    logic             out_ready;
    logic             p_adv;
    logic             emit;
    logic             good_end;
    logic [REM_W-1:0] rem_dec;
    t_lead            lead_id, lead_data;

    assign out_ready  = !r_o_valid || i_m_tready;
    assign p_adv      = r_in_valid && out_ready;
    assign o_s_tready = !r_in_valid || out_ready;

    assign lead_id   = f_lead(r_phase, PH_GAP_ID, r_sync, r_in_byte, BYTE_ID_AM);
    assign lead_data = f_lead(r_phase, PH_GAP_DATA, r_sync, r_in_byte, BYTE_DATA_AM);
    assign rem_dec   = (r_rem != '0) ? r_rem - REM_W'(1) : r_rem;

    always_comb begin
        n_phase  = r_phase;
        n_sync   = r_sync;
        n_fcnt   = r_fcnt;
        n_rem    = r_rem;
        n_off    = r_off;
        n_err    = r_err;
        emit     = 1'b0;
        good_end = !r_err && (r_phase == PH_DCRC ||
                              (r_phase == PH_GAP_ID && r_in_byte == BYTE_GAP));
        if (!r_err) begin
            unique case (r_phase)
                PH_GAP_ID, PH_SYNC_ID, PH_MARK_ID: begin
                    n_phase = lead_id.phase;
                    n_sync  = lead_id.sync;
                    n_err   = lead_id.err;
                    if (lead_id.hit) begin
                        n_phase = PH_HEADER;
                        n_fcnt  = '0;
                    end
                end
                PH_HEADER: begin
                    if (r_fcnt < 3'd3) begin
                        n_fcnt = r_fcnt + 3'd1;
                    end else begin
                        priority if (r_in_byte == SIZE_256) begin
                            n_rem = LEN_256;
                        end else if (r_in_byte == SIZE_512) begin
                            n_rem = LEN_512;
                        end else if (r_in_byte == SIZE_1024) begin
                            n_rem = LEN_1024;
                        end else begin
                            n_err = 1'b1;
                        end
                        n_phase = PH_HCRC;
                        n_fcnt  = '0;
                    end
                end
                PH_HCRC: begin
                    if (r_fcnt == '0) begin
                        n_fcnt = 3'd1;
                    end else begin
                        n_fcnt  = '0;
                        n_phase = PH_GAP_DATA;
                    end
                end
                PH_GAP_DATA, PH_SYNC_DATA, PH_MARK_DATA: begin
                    n_phase = lead_data.phase;
                    n_sync  = lead_data.sync;
                    n_err   = lead_data.err;
                    if (lead_data.hit) begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_off >= CNT_W'(OUT_BYTES)) begin
                        n_err = 1'b1;
                    end else begin
                        emit  = 1'b1;
                        n_off = r_off + CNT_W'(1);
                        n_rem = rem_dec;
                        if (rem_dec == '0) begin
                            n_phase = PH_DCRC;
                            n_fcnt  = '0;
                        end
                    end
                end
                PH_DCRC: begin
                    if (r_fcnt == '0) begin
                        n_fcnt = 3'd1;
                    end else begin
                        n_fcnt  = '0;
                        n_phase = PH_GAP_ID;
                        n_sync  = '0;
                    end
                end
                default: begin
                    n_err = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_GAP_ID;
            r_sync  <= '0;
            r_fcnt  <= '0;
            r_rem   <= '0;
            r_off   <= '0;
            r_err   <= 1'b0;
        end else if (p_adv) begin
            if (r_in_last) begin
                r_phase <= PH_GAP_ID;
                r_sync  <= '0;
                r_fcnt  <= '0;
                r_rem   <= '0;
                r_off   <= '0;
                r_err   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_sync  <= n_sync;
                r_fcnt  <= n_fcnt;
                r_rem   <= n_rem;
                r_off   <= n_off;
                r_err   <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_ready) begin
            r_o_valid <= p_adv && (emit || r_in_last);
        end
        if (p_adv) begin
            r_o_byte   <= emit ? r_in_byte : 8'd0;
            r_o_off    <= emit ? r_off[OFF_W-1:0] : '0;
            r_o_dv     <= emit;
            r_o_last   <= r_in_last;
            r_o_status <= r_in_last && !good_end;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {3'd0, r_o_off, r_o_byte};
    assign o_m_tuser  = {r_o_status, r_o_dv};
    assign o_m_tlast  = r_o_last;

`ifndef SYNTHESIS
    a_off_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[20:8] < OFF_W'(OUT_BYTES)))
        else $error("payload offset beyond output capacity");

    a_track_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (p_adv && r_in_last) |=> (r_phase == PH_GAP_ID && r_off == '0 && !r_err))
        else $error("parser state not cleared after track end");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err && !(p_adv && r_in_last)) |=> r_err)
        else $error("error flag dropped before track end");

    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_rem != '0))
        else $error("payload phase with no bytes remaining");

    a_mark_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MARK_ID || r_phase == PH_MARK_DATA) |-> (r_sync != '0))
        else $error("mark phase without A1 count");
`endif

endmodule
